>>> sv/abfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the alignment band builder.
package abfs_pkg;

  // Position and field widths.
  localparam int POS_W    = 28;
  localparam int MARGIN_W = 16;
  localparam int M10_W    = MARGIN_W + 4;
  localparam int COL_W    = POS_W + 1;
  localparam int ROW_W    = 31;
  localparam int KIND_W   = 3;

  // Signed working width for band arithmetic; wide enough for sums of two
  // positions plus the scaled margin, and never narrower than a row field.
  localparam int AW = (POS_W + 4 > ROW_W) ? POS_W + 4 : ROW_W;

  // The leading gap scales the margin by this factor.
  localparam int LEAD_FACTOR = 10;

  // Configuration port.
  localparam int CFG_IW = 2;
  localparam int CFG_DW = (POS_W > MARGIN_W) ? POS_W : MARGIN_W;
  localparam logic [CFG_IW-1:0] REG_REF_SIZE   = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_QUERY_SIZE = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_MARGIN     = CFG_IW'(2);

  // CIGAR operation kinds; codes above OP_OTHER behave like OP_OTHER.
  localparam logic [KIND_W-1:0] OP_MATCH    = KIND_W'(0);
  localparam logic [KIND_W-1:0] OP_REF_GAP  = KIND_W'(1);
  localparam logic [KIND_W-1:0] OP_QRY_GAP  = KIND_W'(2);
  localparam logic [KIND_W-1:0] OP_REF_SKIP = KIND_W'(3);
  localparam logic [KIND_W-1:0] OP_QRY_SKIP = KIND_W'(4);
  localparam logic [KIND_W-1:0] OP_OTHER    = KIND_W'(5);

  // Job queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // What the back has to build for one accepted beat.
  typedef enum logic [1:0] {
    JOB_CLOSE = 2'd0,  // close the open parallelogram at a skip
    JOB_OPEN  = 2'd1,  // rectangle up to a new aligned block
    JOB_EMPTY = 2'd2,  // end of an empty seed: one full rectangle
    JOB_END   = 2'd3   // end of seed: closing segments
  } job_kind_e;

  typedef struct packed {
    job_kind_e               kind;
    logic                    flag;  // OPEN: leading gap allowed; END: close pending
    logic [POS_W-1:0]        rp;
    logic [POS_W-1:0]        qp;
    logic [POS_W-1:0]        brs;
    logic signed [AW-1:0]    bqs;
  } job_t;

  typedef struct packed {
    logic [POS_W-1:0]    ref_size;
    logic [POS_W-1:0]    query_size;
    logic [MARGIN_W-1:0] margin;
    logic [M10_W-1:0]    margin10;
  } cfg_t;

  // Zero-extend unsigned quantities into the signed working width.
  function automatic logic signed [AW-1:0] pos_ext(input logic [POS_W-1:0] v);
    return signed'({{(AW - POS_W){1'b0}}, v});
  endfunction

  function automatic logic signed [AW-1:0] mar_ext(input logic [MARGIN_W-1:0] v);
    return signed'({{(AW - MARGIN_W){1'b0}}, v});
  endfunction

  function automatic logic signed [AW-1:0] m10_ext(input logic [M10_W-1:0] v);
    return signed'({{(AW - M10_W){1'b0}}, v});
  endfunction

endpackage

>>> sv/abfs_queue.sv
`timescale 1ns / 1ps
// Short job queue that decouples the front from the back.
module abfs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  abfs_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output abfs_pkg::job_t head_o
);

  abfs_pkg::job_t mem_q [abfs_pkg::QDEPTH];

  logic [abfs_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [abfs_pkg::QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == abfs_pkg::QCNT_W'(abfs_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Storage needs no reset; only the pointers and the count are control state.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == abfs_pkg::QPTR_W'(abfs_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == abfs_pkg::QPTR_W'(abfs_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> sv/abfs_front.sv
`timescale 1ns / 1ps
// Front end: accepts CIGAR beats, tracks the seed walk and queues band jobs.
module abfs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  abfs_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [abfs_pkg::KIND_W-1:0]  op_kind_i,
  input  logic [abfs_pkg::POS_W-1:0]   op_length_i,
  input  logic                         end_of_seed_i,
  input  logic                         full_i,
  output logic                         push_o,
  output abfs_pkg::job_t               job_o
);

  logic                               in_blk_q, in_blk_d;
  logic                               ne_q, ne_d;
  logic                               seen_q, seen_d;
  logic [abfs_pkg::POS_W-1:0]         rp_q, rp_d;
  logic [abfs_pkg::POS_W-1:0]         qp_q, qp_d;
  logic [abfs_pkg::POS_W-1:0]         brs_q, brs_d;
  logic signed [abfs_pkg::AW-1:0]     bqs_q, bqs_d;

  logic                               acc;
  logic                               close_ok;
  logic                               adv_r, adv_q, skip;
  logic [abfs_pkg::POS_W:0]           rp_sum, qp_sum;
  logic [abfs_pkg::POS_W-1:0]         rp_sat, qp_sat;
  logic signed [abfs_pkg::AW-1:0]     qp_w;

  // A beat is taken whenever the queue has room for its job.
  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;

  assign qp_w     = abfs_pkg::pos_ext(qp_q);
  assign close_ok = (rp_q > brs_q) && (qp_w > bqs_q);

  // Decode which positions the operation moves.
  always_comb begin
    adv_r = 1'b0;
    adv_q = 1'b0;
    skip  = 1'b0;
    case (op_kind_i)
      abfs_pkg::OP_MATCH: begin
        adv_r = 1'b1;
        adv_q = 1'b1;
      end
      abfs_pkg::OP_REF_GAP:  adv_q = 1'b1;
      abfs_pkg::OP_QRY_GAP:  adv_r = 1'b1;
      abfs_pkg::OP_REF_SKIP: begin
        skip  = 1'b1;
        adv_r = 1'b1;
      end
      abfs_pkg::OP_QRY_SKIP: begin
        skip  = 1'b1;
        adv_q = 1'b1;
      end
      default: ;
    endcase
  end

  // Advance and clamp both positions to the sequence sizes.
  assign rp_sum = {1'b0, rp_q} + {1'b0, (adv_r ? op_length_i : '0)};
  assign qp_sum = {1'b0, qp_q} + {1'b0, (adv_q ? op_length_i : '0)};
  assign rp_sat = (rp_sum > {1'b0, cfg_i.ref_size}) ? cfg_i.ref_size
                                                    : rp_sum[abfs_pkg::POS_W-1:0];
  assign qp_sat = (qp_sum > {1'b0, cfg_i.query_size}) ? cfg_i.query_size
                                                      : qp_sum[abfs_pkg::POS_W-1:0];

  // Walk state update and job generation.
  always_comb begin
    in_blk_d = in_blk_q;
    ne_d     = ne_q;
    seen_d   = seen_q;
    rp_d     = rp_q;
    qp_d     = qp_q;
    brs_d    = brs_q;
    bqs_d    = bqs_q;
    push_o   = 1'b0;
    job_o.kind = abfs_pkg::JOB_OPEN;
    job_o.flag = 1'b0;
    job_o.rp   = rp_q;
    job_o.qp   = qp_q;
    job_o.brs  = brs_q;
    job_o.bqs  = bqs_q;
    if (acc) begin
      if (end_of_seed_i) begin
        push_o     = 1'b1;
        job_o.kind = seen_q ? abfs_pkg::JOB_END : abfs_pkg::JOB_EMPTY;
        job_o.flag = in_blk_q && close_ok;
        // The next seed starts from a clean walk.
        in_blk_d = 1'b0;
        ne_d     = 1'b1;
        seen_d   = 1'b0;
        rp_d     = abfs_pkg::POS_W'(1);
        qp_d     = abfs_pkg::POS_W'(1);
        brs_d    = '0;
        bqs_d    = '0;
      end else begin
        seen_d = 1'b1;
        rp_d   = rp_sat;
        qp_d   = qp_sat;
        if (skip) begin
          if (in_blk_q) begin
            in_blk_d = 1'b0;
            brs_d    = rp_q;
            bqs_d    = qp_w - abfs_pkg::mar_ext(cfg_i.margin);
            if (close_ok) begin
              push_o     = 1'b1;
              job_o.kind = abfs_pkg::JOB_CLOSE;
              ne_d       = 1'b0;
            end
          end
        end else if (!in_blk_q) begin
          push_o     = 1'b1;
          job_o.kind = abfs_pkg::JOB_OPEN;
          job_o.flag = ne_q;
          ne_d       = 1'b0;
          in_blk_d   = 1'b1;
          brs_d      = rp_q;
          bqs_d      = qp_w;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_blk_q <= 1'b0;
      ne_q     <= 1'b1;
      seen_q   <= 1'b0;
      rp_q     <= abfs_pkg::POS_W'(1);
      qp_q     <= abfs_pkg::POS_W'(1);
      brs_q    <= '0;
      bqs_q    <= '0;
    end else begin
      in_blk_q <= in_blk_d;
      ne_q     <= ne_d;
      seen_q   <= seen_d;
      rp_q     <= rp_d;
      qp_q     <= qp_d;
      brs_q    <= brs_d;
      bqs_q    <= bqs_d;
    end
  end

endmodule

>>> sv/abfs_back.sv
`timescale 1ns / 1ps
// Back end: turns queued jobs into band segments, one output beat per cycle while the output is not stalled.
module abfs_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  abfs_pkg::cfg_t                     cfg_i,
  input  abfs_pkg::job_t                     job_i,
  input  logic                               empty_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               is_diagonal_o,
  output logic [abfs_pkg::COL_W-1:0]         col_start_o,
  output logic [abfs_pkg::COL_W-1:0]         col_end_o,
  output logic signed [abfs_pkg::ROW_W-1:0]  row_low_o,
  output logic signed [abfs_pkg::ROW_W-1:0]  row_high_o,
  output logic                               last_of_run_o,
  output logic                               range_done_o
);

  localparam int AW = abfs_pkg::AW;

  // One-hot slot codes; a job builds at most three segments in this order.
  localparam logic [2:0] SLOT_A = 3'b001;
  localparam logic [2:0] SLOT_B = 3'b010;

  typedef struct packed {
    abfs_pkg::job_kind_e        kind;
    logic                       flag;
    logic                       active;   // end: open block starts inside the reference
    logic [abfs_pkg::POS_W-1:0] rp;
    logic [abfs_pkg::POS_W-1:0] qp;
    logic [abfs_pkg::POS_W-1:0] brs;
    logic signed [AW-1:0]       bqs;
    logic signed [AW-1:0]       e1;       // drift + margin when drift is not negative
    logic signed [AW-1:0]       e2;       // margin - drift
    logic signed [AW-1:0]       s_lead;   // column of a leading gap
    logic signed [AW-1:0]       brs_e;    // block start after an end-time close
    logic signed [AW-1:0]       bqs_e;
    logic signed [AW-1:0]       t_end;    // tail width excluding the block start
  } prep_t;

  typedef struct packed {
    logic                 diag;
    logic signed [AW-1:0] c0;
    logic signed [AW-1:0] c1;
    logic signed [AW-1:0] r0;
    logic signed [AW-1:0] r1;
  } seg_t;

  prep_t pre, p_q;
  logic  p_v_q;
  logic [2:0] done_q;

  logic signed [AW-1:0] m_w, m10_w, rs_w, qs_w;
  logic signed [AW-1:0] jrp, jqp, jbrs;
  logic signed [AW-1:0] prp, pqp, pbrs;
  logic signed [AW-1:0] dev, para_r0, para_r1, s_end, lim;
  logic                 lead_ok, tail_ok;
  logic [2:0]           mask, pending, cur, rest;
  logic                 last, out_free, emit, p_adv, final_job;
  seg_t                 seg;

  logic                               out_v_q;
  logic                               diag_q, last_q, done_flag_q;
  logic [abfs_pkg::COL_W-1:0]         c0_q, c1_q;
  logic signed [abfs_pkg::ROW_W-1:0]  r0_q, r1_q;

  assign m_w   = abfs_pkg::mar_ext(cfg_i.margin);
  assign m10_w = abfs_pkg::m10_ext(cfg_i.margin10);
  assign rs_w  = abfs_pkg::pos_ext(cfg_i.ref_size);
  assign qs_w  = abfs_pkg::pos_ext(cfg_i.query_size);

  // Job preparation: the sums that do not depend on the segment order.
  assign jrp  = abfs_pkg::pos_ext(job_i.rp);
  assign jqp  = abfs_pkg::pos_ext(job_i.qp);
  assign jbrs = abfs_pkg::pos_ext(job_i.brs);

  always_comb begin
    pre.kind   = job_i.kind;
    pre.flag   = job_i.flag;
    pre.rp     = job_i.rp;
    pre.qp     = job_i.qp;
    pre.brs    = job_i.brs;
    pre.bqs    = job_i.bqs;
    pre.e1     = jqp + jbrs + m_w - job_i.bqs - jrp;
    pre.e2     = job_i.bqs + jrp + m_w - jqp - jbrs;
    pre.s_lead = jrp - jqp - m10_w;
    pre.t_end  = qs_w + m10_w - jqp;
    pre.brs_e  = job_i.flag ? jrp : jbrs;
    pre.bqs_e  = job_i.flag ? (jqp - m_w) : job_i.bqs;
    pre.active = job_i.flag ? (job_i.rp <= cfg_i.ref_size)
                            : (job_i.brs <= cfg_i.ref_size);
  end

  // Segment decisions for the job held in the build register.
  assign prp  = abfs_pkg::pos_ext(p_q.rp);
  assign pqp  = abfs_pkg::pos_ext(p_q.qp);
  assign pbrs = abfs_pkg::pos_ext(p_q.brs);

  assign dev     = (p_q.e1 >= m_w) ? p_q.e1 : p_q.e2;
  assign para_r0 = p_q.bqs - dev;
  assign para_r1 = p_q.bqs + dev;
  assign lead_ok = p_q.flag && (p_q.s_lead > m_w);
  assign s_end   = p_q.brs_e + p_q.t_end;
  assign lim     = rs_w + AW'(1) - m_w;
  assign tail_ok = p_q.active && (s_end < lim);

  always_comb begin
    case (p_q.kind)
      abfs_pkg::JOB_CLOSE: mask = 3'b001;
      abfs_pkg::JOB_OPEN:  mask = {1'b0, 1'b1, lead_ok};
      abfs_pkg::JOB_EMPTY: mask = 3'b001;
      abfs_pkg::JOB_END:   mask = {p_q.active, tail_ok, p_q.flag};
      default:             mask = 3'b000;
    endcase
  end

  // Pick the lowest segment still to be sent.
  assign pending   = mask & ~done_q;
  assign cur       = pending & (~pending + 3'b001);
  assign rest      = pending & ~cur;
  assign last      = (rest == 3'b000);
  assign final_job = (p_q.kind == abfs_pkg::JOB_END) || (p_q.kind == abfs_pkg::JOB_EMPTY);
  assign out_free  = !out_v_q || out_ready_i;
  assign emit      = p_v_q && (pending != 3'b000) && out_free;
  assign p_adv     = p_v_q && ((pending == 3'b000) || (emit && last));
  assign pop_o     = !empty_i && (!p_v_q || p_adv);

  // Field values of the selected segment.
  always_comb begin
    seg.diag = 1'b0;
    seg.c0   = p_q.brs_e;
    seg.c1   = rs_w + AW'(1);
    seg.r0   = tail_ok ? qs_w : p_q.bqs_e;
    seg.r1   = qs_w + AW'(1);
    case (cur)
      SLOT_A: begin
        case (p_q.kind)
          abfs_pkg::JOB_OPEN: begin
            // Leading gap before the first block.
            seg.c0 = pbrs;
            seg.c1 = p_q.s_lead;
            seg.r0 = p_q.bqs;
            seg.r1 = AW'(1);
          end
          abfs_pkg::JOB_EMPTY: begin
            seg.c0 = '0;
            seg.c1 = rs_w + AW'(1);
            seg.r0 = '0;
            seg.r1 = qs_w + AW'(1);
          end
          default: begin
            // Parallelogram over the closed aligned block.
            seg.diag = 1'b1;
            seg.c0   = pbrs;
            seg.c1   = prp;
            seg.r0   = para_r0;
            seg.r1   = para_r1;
          end
        endcase
      end
      SLOT_B: begin
        if (p_q.kind == abfs_pkg::JOB_OPEN) begin
          seg.c0 = lead_ok ? p_q.s_lead : pbrs;
          seg.c1 = prp;
          seg.r0 = p_q.bqs;
          seg.r1 = pqp + m_w;
        end else begin
          // Tail rectangle ahead of the closing one.
          seg.c0 = p_q.brs_e;
          seg.c1 = s_end;
          seg.r0 = p_q.bqs_e;
          seg.r1 = qs_w + AW'(1);
        end
      end
      default: begin
        // Closing rectangle to the end of the reference.
        seg.c0 = tail_ok ? s_end : p_q.brs_e;
      end
    endcase
  end

  // Build register: one job at a time, refilled from the queue as it retires.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q  <= 1'b0;
      done_q <= 3'b000;
    end else begin
      if (pop_o) begin
        p_v_q  <= 1'b1;
        done_q <= 3'b000;
      end else begin
        if (p_adv) begin
          p_v_q <= 1'b0;
        end
        if (emit) begin
          done_q <= done_q | cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_q <= pre;
    end
  end

  // Output register holding one beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (emit) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      diag_q      <= seg.diag;
      c0_q        <= seg.c0[abfs_pkg::COL_W-1:0];
      c1_q        <= seg.c1[abfs_pkg::COL_W-1:0];
      r0_q        <= seg.r0[abfs_pkg::ROW_W-1:0];
      r1_q        <= seg.r1[abfs_pkg::ROW_W-1:0];
      last_q      <= last;
      done_flag_q <= last && final_job;
    end
  end

  assign out_valid_o   = out_v_q;
  assign is_diagonal_o = diag_q;
  assign col_start_o   = c0_q;
  assign col_end_o     = c1_q;
  assign row_low_o     = r0_q;
  assign row_high_o    = r1_q;
  assign last_of_run_o = last_q;
  assign range_done_o  = done_flag_q;

endmodule

>>> sv/alignment_band_from_seed.sv
`timescale 1ns / 1ps
// Top level of the alignment band builder. A seed alignment enters as CIGAR
// beats closed by an end-of-seed beat; the block returns the rectangle and
// parallelogram segments of the banded search region in column order. One
// input beat is taken per cycle while the four-entry job queue has room, and
// segments leave at one beat per cycle while the receiver is ready; an item
// yields 0 to 3 segments. For each item, the job is written into the queue
// when its beat is taken, moves from the queue into the segment build
// register, and each segment is then registered at the output.
// Configuration registers are written through their own channel, which is
// always ready.
module alignment_band_from_seed (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [abfs_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [abfs_pkg::CFG_DW-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [abfs_pkg::KIND_W-1:0]        op_kind_i,
  input  logic [abfs_pkg::POS_W-1:0]         op_length_i,
  input  logic                               end_of_seed_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               is_diagonal_o,
  output logic [abfs_pkg::COL_W-1:0]         col_start_o,
  output logic [abfs_pkg::COL_W-1:0]         col_end_o,
  output logic signed [abfs_pkg::ROW_W-1:0]  row_low_o,
  output logic signed [abfs_pkg::ROW_W-1:0]  row_high_o,
  output logic                               last_of_run_o,
  output logic                               range_done_o
);

  abfs_pkg::cfg_t cfg_q;
  abfs_pkg::job_t push_job, head_job;
  logic           push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; the scaled margin is kept ready for the back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        abfs_pkg::REG_REF_SIZE:   cfg_q.ref_size <= cfg_wdata_i[abfs_pkg::POS_W-1:0];
        abfs_pkg::REG_QUERY_SIZE: cfg_q.query_size <= cfg_wdata_i[abfs_pkg::POS_W-1:0];
        abfs_pkg::REG_MARGIN: begin
          cfg_q.margin   <= cfg_wdata_i[abfs_pkg::MARGIN_W-1:0];
          cfg_q.margin10 <= abfs_pkg::M10_W'(cfg_wdata_i[abfs_pkg::MARGIN_W-1:0])
                            * abfs_pkg::M10_W'(abfs_pkg::LEAD_FACTOR);
        end
        default: ;
      endcase
    end
  end

  abfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_kind_i     (op_kind_i),
    .op_length_i   (op_length_i),
    .end_of_seed_i (end_of_seed_i),
    .full_i        (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  abfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head_job)
  );

  abfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_i         (head_job),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_diagonal_o (is_diagonal_o),
    .col_start_o   (col_start_o),
    .col_end_o     (col_end_o),
    .row_low_o     (row_low_o),
    .row_high_o    (row_high_o),
    .last_of_run_o (last_of_run_o),
    .range_done_o  (range_done_o)
  );

endmodule

>>> tb/alignment_band_from_seed_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the alignment band builder: CIGAR seeds in, band segments checked.
module alignment_band_from_seed_tb;

  // Cycles the block may still be busy after its last segment, and the stall limit.
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 5000;
  localparam logic [abfs_pkg::POS_W-1:0] POS_MAX = '1;

  // One CIGAR beat as the sender holds it; hold makes the sender wait for a drained band.
  typedef struct {
    logic [abfs_pkg::KIND_W-1:0] kind;
    logic [abfs_pkg::POS_W-1:0]  len;
    logic                        eos;
    bit                          hold;
  } cigar_t;

  // One band segment as the block returns it.
  typedef struct {
    logic                              diag;
    logic [abfs_pkg::COL_W-1:0]        c0;
    logic [abfs_pkg::COL_W-1:0]        c1;
    logic signed [abfs_pkg::ROW_W-1:0] r0;
    logic signed [abfs_pkg::ROW_W-1:0] r1;
    logic                              last;
    logic                              done;
  } band_seg_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [abfs_pkg::CFG_IW-1:0]       cfg_index_i = abfs_pkg::REG_REF_SIZE;
  logic [abfs_pkg::CFG_DW-1:0]       cfg_wdata_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic [abfs_pkg::KIND_W-1:0]       op_kind_i = abfs_pkg::OP_MATCH;
  logic [abfs_pkg::POS_W-1:0]        op_length_i = '0;
  logic                              end_of_seed_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic                              is_diagonal_o;
  logic [abfs_pkg::COL_W-1:0]        col_start_o;
  logic [abfs_pkg::COL_W-1:0]        col_end_o;
  logic signed [abfs_pkg::ROW_W-1:0] row_low_o;
  logic signed [abfs_pkg::ROW_W-1:0] row_high_o;
  logic                              last_of_run_o;
  logic                              range_done_o;

  alignment_band_from_seed uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_kind_i     (op_kind_i),
    .op_length_i   (op_length_i),
    .end_of_seed_i (end_of_seed_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_diagonal_o (is_diagonal_o),
    .col_start_o   (col_start_o),
    .col_end_o     (col_end_o),
    .row_low_o     (row_low_o),
    .row_high_o    (row_high_o),
    .last_of_run_o (last_of_run_o),
    .range_done_o  (range_done_o)
  );

  // Pending seed beats, the beat on the bus, and the segments still owed by the block.
  cigar_t    cigar_q[$];
  cigar_t    op_on_bus;
  band_seg_t band_q[$];
  band_seg_t item_segs[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int quiet_cycles   = 0;

  // Mirror of the configuration registers.
  longint ref_len = 0;
  longint qry_len = 0;
  longint mar     = 0;

  // Mirror of the band builder state.
  bit     in_block;
  longint blk_ref;
  longint blk_qry;
  longint ref_at;
  longint qry_at;
  bit     nothing_out;
  bit     any_op;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_seed();
    in_block    = 1'b0;
    blk_ref     = 0;
    blk_qry     = 0;
    ref_at      = 1;
    qry_at      = 1;
    nothing_out = 1'b1;
    any_op      = 1'b0;
  endfunction

  function automatic void add_seg(bit diag, longint c0, longint c1, longint r0, longint r1);
    band_seg_t s;
    s.diag = diag;
    s.c0   = c0[abfs_pkg::COL_W-1:0];
    s.c1   = c1[abfs_pkg::COL_W-1:0];
    s.r0   = r0[abfs_pkg::ROW_W-1:0];
    s.r1   = r1[abfs_pkg::ROW_W-1:0];
    s.last = 1'b0;
    s.done = 1'b0;
    item_segs.insert(item_segs.size(), s);
    nothing_out = 1'b0;
  endfunction

  // The open parallelogram is emitted only if it advanced in both directions.
  function automatic void close_open_block();
    longint drift;
    if (ref_at > blk_ref && qry_at > blk_qry) begin
      drift = (qry_at - blk_qry) - (ref_at - blk_ref);
      if (drift < 0) drift = -drift;
      drift += mar;
      add_seg(1'b1, blk_ref, ref_at, blk_qry - drift, blk_qry + drift);
    end
  endfunction

  // Work out the band segments that one accepted beat causes and queue them.
  function automatic void build_band_segments(cigar_t it);
    longint rs;
    longint qs;
    longint s;
    longint len;
    int     tail;
    rs = ref_len;
    qs = qry_len;
    item_segs.delete();
    if (it.eos) begin
      if (!any_op) begin
        // An empty seed searches the whole matrix.
        add_seg(1'b0, 0, rs + 1, 0, qs + 1);
      end else begin
        if (in_block && ref_at > blk_ref && qry_at > blk_qry) begin
          close_open_block();
          blk_ref = ref_at;
          blk_qry = qry_at - mar;
        end
        // Closing rectangles, unless the open block already starts past the reference.
        if (blk_ref < rs + 1) begin
          s = blk_ref + (qs - qry_at + abfs_pkg::LEAD_FACTOR * mar);
          if (s < rs + 1 - mar) begin
            add_seg(1'b0, blk_ref, s, blk_qry, qs + 1);
            blk_ref = s;
            blk_qry = qs;
          end
          add_seg(1'b0, blk_ref, rs + 1, blk_qry, qs + 1);
        end
      end
      if (item_segs.size() != 0) begin
        tail = item_segs.size() - 1;
        item_segs[tail].done = 1'b1;
      end
      clear_seed();
    end else begin
      len    = it.len;
      any_op = 1'b1;
      if (it.kind == abfs_pkg::OP_REF_SKIP || it.kind == abfs_pkg::OP_QRY_SKIP) begin
        if (in_block) begin
          close_open_block();
          in_block = 1'b0;
          blk_ref  = ref_at;
          blk_qry  = qry_at - mar;
        end
        if (it.kind == abfs_pkg::OP_REF_SKIP) ref_at += len;
        else qry_at += len;
      end else begin
        if (!in_block) begin
          // A large leading offset gets its own thin rectangle first.
          if (nothing_out) begin
            s = ref_at - qry_at - abfs_pkg::LEAD_FACTOR * mar;
            if (s > mar) begin
              add_seg(1'b0, blk_ref, s, blk_qry, 1);
              blk_ref = s;
            end
          end
          add_seg(1'b0, blk_ref, ref_at, blk_qry, qry_at + mar);
          in_block = 1'b1;
          blk_ref  = ref_at;
          blk_qry  = qry_at;
        end
        // Unknown kinds stay aligned but move neither position.
        case (it.kind)
          abfs_pkg::OP_MATCH: begin
            ref_at += len;
            qry_at += len;
          end
          abfs_pkg::OP_REF_GAP: qry_at += len;
          abfs_pkg::OP_QRY_GAP: ref_at += len;
          default: ;
        endcase
      end
      if (ref_at > rs) ref_at = rs;
      if (qry_at > qs) qry_at = qs;
    end
    if (item_segs.size() != 0) begin
      tail = item_segs.size() - 1;
      item_segs[tail].last = 1'b1;
    end
    foreach (item_segs[i]) band_q.insert(band_q.size(), item_segs[i]);
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 20) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // Sender: presents the next pending beat, idling at random, and predicts on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) build_band_segments(op_on_bus);
      if (!in_valid_i || in_ready_o) begin
        if (cigar_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
            !(cigar_q[0].hold && band_q.size() != 0)) begin
          op_on_bus = cigar_q.pop_front();
          in_valid_i    <= 1'b1;
          op_kind_i     <= op_on_bus.kind;
          op_length_i   <= op_on_bus.len;
          end_of_seed_i <= op_on_bus.eos;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks every accepted segment beat.
  always @(posedge clk_i or negedge rst_ni) begin
    band_seg_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (band_q.size() == 0) begin
          report_mismatch($sformatf("segment %0h..%0h with nothing expected",
                                    col_start_o, col_end_o));
        end else begin
          want = band_q.pop_front();
          if (is_diagonal_o !== want.diag)
            report_mismatch($sformatf("is_diagonal %b, want %b", is_diagonal_o, want.diag));
          if (col_start_o !== want.c0)
            report_mismatch($sformatf("col_start %0h, want %0h", col_start_o, want.c0));
          if (col_end_o !== want.c1)
            report_mismatch($sformatf("col_end %0h, want %0h", col_end_o, want.c1));
          if (row_low_o !== want.r0)
            report_mismatch($sformatf("row_low %0h, want %0h", row_low_o, want.r0));
          if (row_high_o !== want.r1)
            report_mismatch($sformatf("row_high %0h, want %0h", row_high_o, want.r1));
          if (last_of_run_o !== want.last)
            report_mismatch($sformatf("last_of_run %b, want %b", last_of_run_o, want.last));
          if (range_done_o !== want.done)
            report_mismatch($sformatf("range_done %b, want %b", range_done_o, want.done));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [abfs_pkg::CFG_IW-1:0] idx,
                           input logic [abfs_pkg::CFG_DW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      abfs_pkg::REG_REF_SIZE:   ref_len = val[abfs_pkg::POS_W-1:0];
      abfs_pkg::REG_QUERY_SIZE: qry_len = val[abfs_pkg::POS_W-1:0];
      abfs_pkg::REG_MARGIN:     mar     = val[abfs_pkg::MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_band(input logic [abfs_pkg::POS_W-1:0] rs,
                          input logic [abfs_pkg::POS_W-1:0] qs,
                          input logic [abfs_pkg::MARGIN_W-1:0] m);
    write_reg(abfs_pkg::REG_REF_SIZE, abfs_pkg::CFG_DW'(rs));
    write_reg(abfs_pkg::REG_QUERY_SIZE, abfs_pkg::CFG_DW'(qs));
    write_reg(abfs_pkg::REG_MARGIN, abfs_pkg::CFG_DW'(m));
  endtask

  // Wait until every beat is sent and every segment seen, then let the block settle.
  task automatic wait_quiet();
    while (cigar_q.size() != 0 || in_valid_i || band_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(negedge clk_i);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic void push_op(logic [abfs_pkg::KIND_W-1:0] kind,
                                  logic [abfs_pkg::POS_W-1:0] len);
    cigar_t c;
    c.kind = kind;
    c.len  = len;
    c.eos  = 1'b0;
    c.hold = 1'b0;
    cigar_q.insert(cigar_q.size(), c);
  endfunction

  function automatic void push_end(bit hold);
    cigar_t c;
    c.kind = abfs_pkg::KIND_W'($urandom);
    c.len  = abfs_pkg::POS_W'($urandom);
    c.eos  = 1'b1;
    c.hold = hold;
    cigar_q.insert(cigar_q.size(), c);
  endfunction

  // Random seeds: mostly CIGAR runs mixing skips and aligned stretches, some empty.
  task automatic queue_random_seeds(input int n_items,
                                    input logic [abfs_pkg::POS_W-1:0] len_hi);
    int                          count;
    int                          n_ops;
    int                          pick;
    int                          roll;
    bit                          first_end;
    logic [abfs_pkg::KIND_W-1:0] kind;
    logic [abfs_pkg::POS_W-1:0]  len;
    count     = 0;
    first_end = 1'b1;
    @(negedge clk_i);
    while (count < n_items) begin
      n_ops = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < n_ops; i++) begin
        pick = $urandom_range(99);
        if (pick < 35)      kind = abfs_pkg::OP_MATCH;
        else if (pick < 45) kind = abfs_pkg::OP_REF_GAP;
        else if (pick < 55) kind = abfs_pkg::OP_QRY_GAP;
        else if (pick < 70) kind = abfs_pkg::OP_REF_SKIP;
        else if (pick < 85) kind = abfs_pkg::OP_QRY_SKIP;
        else                kind = abfs_pkg::KIND_W'($urandom_range(abfs_pkg::OP_OTHER, 7));
        roll = $urandom_range(19);
        if (roll == 0)      len = abfs_pkg::POS_W'($urandom);
        else if (roll == 1) len = '0;
        else                len = abfs_pkg::POS_W'($urandom_range(1, len_hi));
        push_op(kind, len);
        count++;
      end
      push_end(first_end || $urandom_range(5) == 0);
      first_end = 1'b0;
      count++;
    end
  endtask

  initial begin
    clear_seed();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed seeds: empty seed, leading gap, every kind, empty parallelogram, saturation.
    set_band(28'd100, 28'd80, 16'd2);
    @(negedge clk_i);
    push_end(1'b0);
    push_op(abfs_pkg::OP_REF_SKIP, 28'd30);
    push_op(abfs_pkg::OP_MATCH, 28'd10);
    push_op(abfs_pkg::OP_REF_GAP, 28'd3);
    push_op(abfs_pkg::OP_QRY_GAP, 28'd4);
    push_op(abfs_pkg::OP_OTHER, 28'd9);
    push_op(abfs_pkg::KIND_W'(6), 28'd0);
    push_op(abfs_pkg::KIND_W'(7), 28'd1);
    push_op(abfs_pkg::OP_QRY_SKIP, 28'd5);
    push_op(abfs_pkg::OP_OTHER, 28'd3);
    push_op(abfs_pkg::OP_QRY_SKIP, 28'd2);
    push_op(abfs_pkg::OP_MATCH, 28'd200);
    push_end(1'b0);
    push_op(abfs_pkg::OP_MATCH, POS_MAX);
    push_end(1'b1);
    wait_quiet();

    // Zero sizes: an aligned block past the reference leaves nothing to close.
    set_band(28'd0, 28'd0, 16'd0);
    @(negedge clk_i);
    push_op(abfs_pkg::OP_OTHER, 28'd4);
    push_end(1'b0);
    push_op(abfs_pkg::OP_QRY_SKIP, 28'd3);
    push_end(1'b0);
    push_end(1'b0);
    push_op(abfs_pkg::OP_MATCH, 28'd5);
    push_op(abfs_pkg::OP_REF_SKIP, 28'd5);
    push_end(1'b0);
    wait_quiet();

    // Random seeds, sender idling.
    set_band(28'd300, 28'd250, 16'd3);
    set_idling(71, 0);
    queue_random_seeds(15, 28'd60);
    wait_quiet();

    // Receiver stalling, no margin.
    set_band(28'd150, 28'd400, 16'd0);
    set_idling(0, 71);
    queue_random_seeds(15, 28'd60);
    wait_quiet();

    // Random sizes, both sides idling now and then.
    set_band(abfs_pkg::POS_W'($urandom_range(0, 500)), abfs_pkg::POS_W'($urandom_range(0, 500)),
             abfs_pkg::MARGIN_W'($urandom_range(0, 20)));
    set_idling(15, 15);
    queue_random_seeds(15, 28'd80);
    wait_quiet();

    // Largest sizes and margin with long operations, no idling.
    set_band(POS_MAX, POS_MAX, 16'hFFFF);
    set_idling(0, 0);
    queue_random_seeds(12, POS_MAX);
    wait_quiet();

    // Short query against a wide margin, mixed idling.
    set_band(28'd1000, 28'd5, 16'hFFFF);
    set_idling(40, 40);
    queue_random_seeds(10, 28'd300);
    wait_quiet();

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
